@@ rtl/les_pkg.sv @@
// Shared types and constants for the LED identify effect sequencer.
// Holds the input and result word structs, the configuration struct and all codes.
// No dependencies.
package les_pkg;

    typedef struct packed {
        logic       cmd;
        logic [2:0] effect_code;
    } t_in_word;

    typedef struct packed {
        logic [9:0] duty;
        logic [6:0] brightness;
        logic       running;
    } t_out_word;

    typedef struct packed {
        logic        active_low;
        logic [15:0] blink_len;
        logic [7:0]  breathe_cycles;
        logic [15:0] flash_len;
    } t_cfg;

    localparam logic CMD_IDENTIFY = 1'b1;

    localparam logic [2:0] FX_NONE    = 3'd0;
    localparam logic [2:0] FX_BLINK   = 3'd1;
    localparam logic [2:0] FX_BREATHE = 3'd2;
    localparam logic [2:0] FX_OKAY    = 3'd3;
    localparam logic [2:0] FX_FLASH   = 3'd4;

    localparam logic [2:0] CODE_BLINK   = 3'd0;
    localparam logic [2:0] CODE_BREATHE = 3'd1;
    localparam logic [2:0] CODE_OKAY    = 3'd2;
    localparam logic [2:0] CODE_FLASH   = 3'd3;
    localparam logic [2:0] CODE_FINISH  = 3'd4;

    localparam logic [1:0] REG_ACTIVE_LOW     = 2'd0;
    localparam logic [1:0] REG_BLINK_TOTAL    = 2'd1;
    localparam logic [1:0] REG_BREATHE_CYCLES = 2'd2;
    localparam logic [1:0] REG_FLASH_TOTAL    = 2'd3;

    localparam logic        RST_ACTIVE_LOW     = 1'b1;
    localparam logic [15:0] RST_BLINK_TOTAL    = 16'd1000;
    localparam logic [7:0]  RST_BREATHE_CYCLES = 8'd15;
    localparam logic [15:0] RST_FLASH_TOTAL    = 16'd200;

    localparam logic [6:0] PCT_FULL = 7'd100;
    localparam logic [6:0] PCT_OFF  = 7'd0;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned Q30_PI  = 64'd3373259426;

endpackage

@@ rtl/led_identify_effect_sequencer.sv @@
// Top level of the LED identify effect sequencer: input register, effect engine,
// result register and configuration registers. Depends on les_pkg, les_regs, les_engine.
// An accepted word waits in the input register; its result word from the engine is stored
// in the result register. Throughput: one word per cycle while the output is not stalled;
// the engine updates its state once per processed word.
// Reset (synchronous, active low) empties both registers, stops any effect and loads
// the default configuration.
module led_identify_effect_sequencer #(
    parameter int TICK_PERIOD_MS = 20,
    parameter int MAX_DUTY       = 1023,
    parameter int BREATHE_PERIOD = 1000,
    parameter int PULSE_MS       = 100
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  les_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output les_pkg::t_out_word   o_out_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic                r_in_valid;
    les_pkg::t_in_word   r_in_word;
    logic                r_out_valid;
    les_pkg::t_out_word  r_out_word;
    logic                w_adv;
    logic                w_go;
    les_pkg::t_cfg       w_cfg;
    les_pkg::t_out_word  w_result;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_go       = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    les_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    les_engine #(
        .TICK_PERIOD_MS (TICK_PERIOD_MS),
        .MAX_DUTY       (MAX_DUTY),
        .BREATHE_PERIOD (BREATHE_PERIOD),
        .PULSE_MS       (PULSE_MS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_word   (r_in_word),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ rtl/les_regs.sv @@
// Configuration register file with an APB-style write and read port.
// Depends on les_pkg for the configuration struct, register indexes and reset values.
module les_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output les_pkg::t_cfg     o_cfg
);

    les_pkg::t_cfg r_cfg;
    logic          w_write;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low     <= les_pkg::RST_ACTIVE_LOW;
            r_cfg.blink_len      <= les_pkg::RST_BLINK_TOTAL;
            r_cfg.breathe_cycles <= les_pkg::RST_BREATHE_CYCLES;
            r_cfg.flash_len      <= les_pkg::RST_FLASH_TOTAL;
        end else if (w_write) begin
            unique case (paddr[3:2])
                les_pkg::REG_ACTIVE_LOW:     r_cfg.active_low     <= pwdata[0];
                les_pkg::REG_BLINK_TOTAL:    r_cfg.blink_len      <= pwdata[15:0];
                les_pkg::REG_BREATHE_CYCLES: r_cfg.breathe_cycles <= pwdata[7:0];
                les_pkg::REG_FLASH_TOTAL:    r_cfg.flash_len      <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            les_pkg::REG_ACTIVE_LOW:     prdata = {31'd0, r_cfg.active_low};
            les_pkg::REG_BLINK_TOTAL:    prdata = {16'd0, r_cfg.blink_len};
            les_pkg::REG_BREATHE_CYCLES: prdata = {24'd0, r_cfg.breathe_cycles};
            les_pkg::REG_FLASH_TOTAL:    prdata = {16'd0, r_cfg.flash_len};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

@@ rtl/les_breathe_rom.sv @@
// Sine-squared brightness table for the breathe effect, one entry per reachable phase.
// Entries are built at elaboration from a Q30 sine series. Depends on les_pkg.
module les_breathe_rom #(
    parameter int BREATHE_PERIOD = 1000,
    parameter int PHASE_STEP_MS  = 20,
    parameter int INDEX_W        = 6
) (
    input  logic [INDEX_W-1:0] i_index,
    output logic [6:0]         o_pct
);

    localparam int NUM_PHASES = BREATHE_PERIOD / PHASE_STEP_MS;
    localparam int ROM_DEPTH  = 1 << INDEX_W;

    function automatic logic [6:0] f_pct(input int idx);
        longint unsigned p;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned acc;
        longint unsigned s;
        longint unsigned s2;
        longint unsigned v;
        p = longint'(idx) * longint'(PHASE_STEP_MS);
        if (2 * p > longint'(BREATHE_PERIOD)) begin
            p = longint'(BREATHE_PERIOD) - p;
        end
        x   = (les_pkg::Q30_PI * p) / BREATHE_PERIOD;
        x2  = (x * x) >> 30;
        acc = les_pkg::Q30_ONE;
        acc = les_pkg::Q30_ONE - (((x2 * acc) >> 30) / 156);
        acc = les_pkg::Q30_ONE - (((x2 * acc) >> 30) / 110);
        acc = les_pkg::Q30_ONE - (((x2 * acc) >> 30) / 72);
        acc = les_pkg::Q30_ONE - (((x2 * acc) >> 30) / 42);
        acc = les_pkg::Q30_ONE - (((x2 * acc) >> 30) / 20);
        acc = les_pkg::Q30_ONE - (((x2 * acc) >> 30) / 6);
        s   = (x * acc) >> 30;
        s2  = (s * s) >> 30;
        v   = (100 * s2 + (64'd1 << 16)) >> 30;
        if (v > 100) begin
            v = 100;
        end
        return v[6:0];
    endfunction

    logic [6:0] w_rom [ROM_DEPTH];

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        if (g < NUM_PHASES) begin : g_used
            assign w_rom[g] = f_pct(g);
        end else begin : g_unused
            assign w_rom[g] = les_pkg::PCT_OFF;
        end
    end

    assign o_pct = w_rom[i_index];

endmodule

@@ rtl/les_engine.sv @@
// Effect state and next-item logic: effect, elapsed time, breathe phase and held brightness.
// Produces the result word for the word being processed. Depends on les_pkg, les_breathe_rom.
module les_engine #(
    parameter int TICK_PERIOD_MS = 20,
    parameter int MAX_DUTY       = 1023,
    parameter int BREATHE_PERIOD = 1000,
    parameter int PULSE_MS       = 100
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  les_pkg::t_in_word    i_word,
    input  les_pkg::t_cfg        i_cfg,
    output les_pkg::t_out_word   o_result
);

    function automatic int f_gcd(input int a, input int b);
        int x;
        int y;
        x = a;
        y = b;
        while (x != y) begin
            if (x > y) begin
                x = x - y;
            end else begin
                y = y - x;
            end
        end
        return x;
    endfunction

    function automatic logic [15:0] f_scaled(input int pct);
        longint unsigned v;
        v = (longint'(pct) * longint'(MAX_DUTY)) / 100;
        return v[15:0];
    endfunction

    localparam int TICK_MOD   = TICK_PERIOD_MS % BREATHE_PERIOD;
    localparam int GCD_MS     = f_gcd(TICK_PERIOD_MS, BREATHE_PERIOD);
    localparam int NUM_PHASES = BREATHE_PERIOD / GCD_MS;
    localparam int STEP       = TICK_MOD / GCD_MS;
    localparam int PW         = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
    localparam int BLINK_MAX  = 65535;
    localparam int BR_MAX     = BREATHE_PERIOD * 255;
    localparam int OK_MAX     = PULSE_MS * 4;
    localparam int TOTAL_MAX  = (BR_MAX > BLINK_MAX)
                                ? ((OK_MAX > BR_MAX) ? OK_MAX : BR_MAX)
                                : ((OK_MAX > BLINK_MAX) ? OK_MAX : BLINK_MAX);
    localparam int EW         = $clog2(TOTAL_MAX + TICK_PERIOD_MS + 1);
    localparam logic [15:0] MAX_D = 16'(MAX_DUTY);

    logic [2:0]    r_effect;
    logic [EW-1:0] r_elapsed;
    logic [PW-1:0] r_phase;
    logic [6:0]    r_held;
    logic [2:0]    n_effect;
    logic [EW-1:0] n_elapsed;
    logic [PW-1:0] n_phase;
    logic [6:0]    n_held;
    logic [2:0]    w_next_fx;
    logic [EW-1:0] w_t;
    logic [EW-1:0] w_total;
    logic [PW:0]   w_phase_sum;
    logic [PW-1:0] w_phase_next;
    logic [6:0]    w_breathe_pct;
    logic [15:0]   w_scaled;
    logic [15:0]   w_duty;
    logic [15:0]   w_scale_rom [128];

    for (genvar g = 0; g < 128; g++) begin : g_scale
        if (g <= 100) begin : g_used
            assign w_scale_rom[g] = f_scaled(g);
        end else begin : g_unused
            assign w_scale_rom[g] = 16'd0;
        end
    end

    les_breathe_rom #(
        .BREATHE_PERIOD (BREATHE_PERIOD),
        .PHASE_STEP_MS  (GCD_MS),
        .INDEX_W        (PW)
    ) u_rom (
        .i_index (w_phase_next),
        .o_pct   (w_breathe_pct)
    );

    assign w_t         = r_elapsed + EW'(TICK_PERIOD_MS);
    assign w_phase_sum = {1'b0, r_phase} + (PW+1)'(STEP);
    assign w_phase_next = (w_phase_sum >= (PW+1)'(NUM_PHASES))
                          ? PW'(w_phase_sum - (PW+1)'(NUM_PHASES))
                          : w_phase_sum[PW-1:0];

    always_comb begin
        case (r_effect)
            les_pkg::FX_BLINK:   w_total = EW'(i_cfg.blink_len);
            les_pkg::FX_BREATHE: w_total = EW'(BREATHE_PERIOD) * EW'(i_cfg.breathe_cycles);
            les_pkg::FX_OKAY:    w_total = EW'(OK_MAX);
            default:             w_total = EW'(i_cfg.flash_len);
        endcase
    end

    always_comb begin
        unique case (i_word.effect_code)
            les_pkg::CODE_BLINK:   w_next_fx = les_pkg::FX_BLINK;
            les_pkg::CODE_BREATHE: w_next_fx = les_pkg::FX_BREATHE;
            les_pkg::CODE_OKAY:    w_next_fx = les_pkg::FX_OKAY;
            les_pkg::CODE_FLASH:   w_next_fx = les_pkg::FX_FLASH;
            les_pkg::CODE_FINISH:  w_next_fx = r_effect;
            default:               w_next_fx = les_pkg::FX_NONE;
        endcase
    end

    always_comb begin
        n_effect  = r_effect;
        n_elapsed = r_elapsed;
        n_phase   = r_phase;
        n_held    = r_held;
        if (i_word.cmd == les_pkg::CMD_IDENTIFY) begin
            n_effect  = w_next_fx;
            n_elapsed = '0;
            n_phase   = '0;
            if (w_next_fx == les_pkg::FX_NONE) begin
                n_held = les_pkg::PCT_OFF;
            end
        end else if (r_effect != les_pkg::FX_NONE) begin
            if (w_t >= w_total) begin
                n_effect  = les_pkg::FX_NONE;
                n_elapsed = '0;
                n_phase   = '0;
                n_held    = les_pkg::PCT_OFF;
            end else begin
                n_elapsed = w_t;
                n_phase   = w_phase_next;
                case (r_effect)
                    les_pkg::FX_BLINK: begin
                        n_held = (w_t < EW'(i_cfg.blink_len >> 1))
                                 ? les_pkg::PCT_FULL : les_pkg::PCT_OFF;
                    end
                    les_pkg::FX_BREATHE: begin
                        n_held = w_breathe_pct;
                    end
                    les_pkg::FX_OKAY: begin
                        if (w_t < EW'(PULSE_MS)) begin
                            n_held = les_pkg::PCT_FULL;
                        end else if (w_t < EW'(2 * PULSE_MS)) begin
                            n_held = les_pkg::PCT_OFF;
                        end else if (w_t < EW'(3 * PULSE_MS)) begin
                            n_held = les_pkg::PCT_FULL;
                        end else begin
                            n_held = les_pkg::PCT_OFF;
                        end
                    end
                    default: begin
                        n_held = les_pkg::PCT_FULL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect  <= les_pkg::FX_NONE;
            r_elapsed <= '0;
            r_phase   <= '0;
            r_held    <= les_pkg::PCT_OFF;
        end else if (i_go) begin
            r_effect  <= n_effect;
            r_elapsed <= n_elapsed;
            r_phase   <= n_phase;
            r_held    <= n_held;
        end
    end

    assign w_scaled = w_scale_rom[n_held];
    assign w_duty   = i_cfg.active_low ? (MAX_D - w_scaled) : w_scaled;

    assign o_result.duty       = w_duty[9:0];
    assign o_result.brightness = n_held;
    assign o_result.running    = (n_effect != les_pkg::FX_NONE);

endmodule

@@ bench/led_identify_effect_sequencer_test.sv @@
// Self-checking bench for led_identify_effect_sequencer: tick and identify words go in
// through a queue-fed driver, result words are checked against an in-bench LED model.
// Depends on les_pkg and the led_identify_effect_sequencer RTL.
`timescale 1ns / 100ps

module led_identify_effect_sequencer_test;

    localparam int unsigned TICK_MS      = 20;
    localparam int unsigned DUTY_MAX     = 1023;
    localparam int unsigned BREATHE_MS   = 1000;
    localparam int unsigned PULSE_LEN_MS = 100;

    localparam logic       CMD_TICK    = 1'b0;
    localparam logic [2:0] CODE_STOP   = 3'd5;
    localparam logic [2:0] CODE_SPARE6 = 3'd6;
    localparam logic [2:0] CODE_SPARE7 = 3'd7;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    les_pkg::t_in_word   i_in_word = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    les_pkg::t_out_word  o_out_word;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [3:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    les_pkg::t_in_word   pending[$];
    les_pkg::t_out_word  drive_expected[$];
    int                  queued_total = 0;
    int                  results_total = 0;
    int                  fail_count = 0;
    int                  idle_pct = 37;
    logic                send_hold = 1'b0;
    logic                long_hold_req = 1'b0;
    logic                rx_blocked = 1'b0;
    logic                in_hs = 1'b0;

    les_pkg::t_cfg       cfg_shadow;
    logic [2:0]          fx_now;
    int unsigned         run_ms;
    logic [6:0]          pct_held;

    led_identify_effect_sequencer #(
        .TICK_PERIOD_MS(TICK_MS),
        .MAX_DUTY(DUTY_MAX),
        .BREATHE_PERIOD(BREATHE_MS),
        .PULSE_MS(PULSE_LEN_MS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_word(i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word(o_out_word),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [6:0] fade_pct(input int unsigned phase);
        longint unsigned p, x, x2, acc, s, s2, v;
        p = phase;
        if (2 * p > BREATHE_MS) begin
            p = BREATHE_MS - p;
        end
        x = (les_pkg::Q30_PI * p) / BREATHE_MS;
        x2 = (x * x) >> 30;
        acc = les_pkg::Q30_ONE;
        for (int k = 6; k >= 1; k--) begin
            acc = les_pkg::Q30_ONE - (((x2 * acc) >> 30) / 64'(2 * k * (2 * k + 1)));
        end
        s = (x * acc) >> 30;
        s2 = (s * s) >> 30;
        v = (100 * s2 + (64'd1 << 16)) >> 30;
        return (v > les_pkg::PCT_FULL) ? les_pkg::PCT_FULL : 7'(v);
    endfunction

    function automatic les_pkg::t_out_word led_drive_after(input les_pkg::t_in_word w);
        les_pkg::t_out_word res;
        logic [2:0]         next_fx;
        int unsigned        t, total, scaled;
        if (w.cmd == les_pkg::CMD_IDENTIFY) begin
            case (w.effect_code)
                les_pkg::CODE_BLINK:   next_fx = les_pkg::FX_BLINK;
                les_pkg::CODE_BREATHE: next_fx = les_pkg::FX_BREATHE;
                les_pkg::CODE_OKAY:    next_fx = les_pkg::FX_OKAY;
                les_pkg::CODE_FLASH:   next_fx = les_pkg::FX_FLASH;
                les_pkg::CODE_FINISH:  next_fx = fx_now;
                default:               next_fx = les_pkg::FX_NONE;
            endcase
            fx_now = next_fx;
            run_ms = 0;
            if (next_fx == les_pkg::FX_NONE) begin
                pct_held = les_pkg::PCT_OFF;
            end
        end else if (fx_now != les_pkg::FX_NONE) begin
            t = run_ms + TICK_MS;
            case (fx_now)
                les_pkg::FX_BLINK:   total = cfg_shadow.blink_len;
                les_pkg::FX_BREATHE: total = BREATHE_MS * cfg_shadow.breathe_cycles;
                les_pkg::FX_OKAY:    total = PULSE_LEN_MS * 4;
                default:             total = cfg_shadow.flash_len;
            endcase
            if (t >= total) begin
                fx_now = les_pkg::FX_NONE;
                run_ms = 0;
                pct_held = les_pkg::PCT_OFF;
            end else begin
                run_ms = t;
                case (fx_now)
                    les_pkg::FX_BLINK: begin
                        pct_held = (t < cfg_shadow.blink_len / 2)
                                   ? les_pkg::PCT_FULL : les_pkg::PCT_OFF;
                    end
                    les_pkg::FX_BREATHE: pct_held = fade_pct(t % BREATHE_MS);
                    les_pkg::FX_OKAY: begin
                        pct_held = (((t / PULSE_LEN_MS) & 1) == 0)
                                   ? les_pkg::PCT_FULL : les_pkg::PCT_OFF;
                    end
                    default: pct_held = les_pkg::PCT_FULL;
                endcase
            end
        end
        scaled = pct_held * DUTY_MAX / les_pkg::PCT_FULL;
        res.duty = 10'(cfg_shadow.active_low ? DUTY_MAX - scaled : scaled);
        res.brightness = pct_held;
        res.running = (fx_now != les_pkg::FX_NONE);
        return res;
    endfunction

    // Driver: offers the next pending word once the current one has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_hs) begin
            if (pending.size() > 0 && !send_hold && $urandom_range(99) >= idle_pct) begin
                i_in_word <= pending.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !rx_blocked && ($urandom_range(99) >= idle_pct);
        end
    end

    initial begin : receiver_hold
        wait (long_hold_req);
        rx_blocked = 1'b1;
        repeat (300) @(posedge i_clk);
        rx_blocked = 1'b0;
    end

    // Monitor: checks each result word against the oldest prediction, then
    // predicts the word accepted at this edge.
    always @(posedge i_clk) begin : monitor
        les_pkg::t_out_word want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_total++;
                if (drive_expected.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result word duty=%0d pct=%0d run=%0b",
                                 o_out_word.duty, o_out_word.brightness, o_out_word.running);
                    end
                end else begin
                    want = drive_expected.pop_front();
                    if (o_out_word.duty !== want.duty ||
                        o_out_word.brightness !== want.brightness ||
                        o_out_word.running !== want.running) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch at %0t: expected duty=%0d pct=%0d run=%0b, %s",
                                     $realtime, want.duty, want.brightness, want.running,
                                     $sformatf("got duty=%0d pct=%0d run=%0b",
                                               o_out_word.duty, o_out_word.brightness,
                                               o_out_word.running));
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                drive_expected.push_back(led_drive_after(i_in_word));
            end
        end
        in_hs <= i_rst_n && i_in_valid && o_in_ready;
    end

    task automatic add_word(input logic cmd, input logic [2:0] code);
        les_pkg::t_in_word w;
        w.cmd = cmd;
        w.effect_code = code;
        pending.push_back(w);
        queued_total++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic al, input logic [15:0] blink_ms,
                              input logic [7:0] cycles, input logic [15:0] flash_ms);
        write_reg(les_pkg::REG_ACTIVE_LOW, 32'(al));
        write_reg(les_pkg::REG_BLINK_TOTAL, 32'(blink_ms));
        write_reg(les_pkg::REG_BREATHE_CYCLES, 32'(cycles));
        write_reg(les_pkg::REG_FLASH_TOTAL, 32'(flash_ms));
        cfg_shadow.active_low = al;
        cfg_shadow.blink_len = blink_ms;
        cfg_shadow.breathe_cycles = cycles;
        cfg_shadow.flash_len = flash_ms;
    endtask

    task automatic wait_drained();
        while (results_total != queued_total) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly an effect start followed by enough ticks to run it out, with
    // interruptions, finish and stop commands and unknown codes mixed in.
    task automatic queue_effect_runs(input int count);
        int         made, span, run_len;
        logic [2:0] code;
        made = 0;
        while (made < count) begin
            if ($urandom_range(9) < 8) begin
                code = 3'($urandom_range(les_pkg::CODE_FLASH, les_pkg::CODE_BLINK));
            end else begin
                code = 3'($urandom());
            end
            add_word(les_pkg::CMD_IDENTIFY, code);
            made++;
            case (code)
                les_pkg::CODE_BLINK:   span = cfg_shadow.blink_len / TICK_MS;
                les_pkg::CODE_BREATHE: span = cfg_shadow.breathe_cycles * (BREATHE_MS / TICK_MS);
                les_pkg::CODE_OKAY:    span = 4 * PULSE_LEN_MS / TICK_MS;
                les_pkg::CODE_FLASH:   span = cfg_shadow.flash_len / TICK_MS;
                default:               span = 3;
            endcase
            if (span > 60) begin
                span = ($urandom_range(9) == 0) ? 150 : 60;
            end
            if ($urandom_range(3) == 0) begin
                run_len = $urandom_range(span);
            end else begin
                run_len = span + $urandom_range(2);
            end
            for (int i = 0; i < run_len; i++) begin
                if ($urandom_range(49) == 0) begin
                    add_word(les_pkg::CMD_IDENTIFY,
                             3'($urandom_range(CODE_SPARE7, les_pkg::CODE_FINISH)));
                end else begin
                    add_word(CMD_TICK, 3'($urandom()));
                end
            end
            made += run_len;
        end
    endtask

    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        cfg_shadow.active_low = les_pkg::RST_ACTIVE_LOW;
        cfg_shadow.blink_len = les_pkg::RST_BLINK_TOTAL;
        cfg_shadow.breathe_cycles = les_pkg::RST_BREATHE_CYCLES;
        cfg_shadow.flash_len = les_pkg::RST_FLASH_TOTAL;
        fx_now = les_pkg::FX_NONE;
        run_ms = 0;
        pct_held = les_pkg::PCT_OFF;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Default configuration: idle behavior, every code and a short run of each effect.
        add_word(CMD_TICK, CODE_SPARE7);
        add_word(les_pkg::CMD_IDENTIFY, les_pkg::CODE_FINISH);
        add_word(les_pkg::CMD_IDENTIFY, CODE_STOP);
        add_word(les_pkg::CMD_IDENTIFY, CODE_SPARE6);
        add_word(les_pkg::CMD_IDENTIFY, CODE_SPARE7);
        add_word(les_pkg::CMD_IDENTIFY, les_pkg::CODE_BREATHE);
        add_word(CMD_TICK, les_pkg::CODE_BLINK);
        add_word(CMD_TICK, les_pkg::CODE_BLINK);
        add_word(les_pkg::CMD_IDENTIFY, les_pkg::CODE_FINISH);
        add_word(CMD_TICK, les_pkg::CODE_BLINK);
        add_word(les_pkg::CMD_IDENTIFY, les_pkg::CODE_FLASH);
        add_word(CMD_TICK, les_pkg::CODE_BLINK);
        add_word(les_pkg::CMD_IDENTIFY, les_pkg::CODE_BLINK);
        add_word(CMD_TICK, les_pkg::CODE_BLINK);
        add_word(les_pkg::CMD_IDENTIFY, les_pkg::CODE_OKAY);
        repeat (6) add_word(CMD_TICK, les_pkg::CODE_BLINK);
        add_word(les_pkg::CMD_IDENTIFY, CODE_STOP);
        add_word(CMD_TICK, les_pkg::CODE_BLINK);
        wait_drained();

        // Zero totals end the effect on its first tick.
        set_config(1'b0, 16'd0, 8'd0, 16'd0);
        add_word(les_pkg::CMD_IDENTIFY, les_pkg::CODE_BLINK);
        add_word(CMD_TICK, les_pkg::CODE_BLINK);
        add_word(les_pkg::CMD_IDENTIFY, les_pkg::CODE_BREATHE);
        add_word(CMD_TICK, les_pkg::CODE_BLINK);
        add_word(les_pkg::CMD_IDENTIFY, les_pkg::CODE_FLASH);
        add_word(CMD_TICK, les_pkg::CODE_BLINK);
        wait_drained();

        set_config(1'b0, 16'd20, 8'd1, 16'd20);
        queue_effect_runs(300);
        long_hold_req = 1'b1;
        wait_drained();

        idle_pct = 0;
        set_config(1'b1, 16'hFFFF, 8'hFF, 16'hFFFF);
        queue_effect_runs(300);
        wait_drained();
        idle_pct = 37;

        for (int ph = 0; ph < 4; ph++) begin
            set_config(1'($urandom_range(1)), 16'($urandom_range(400, 20)),
                       8'($urandom_range(3, 1)), 16'($urandom_range(400, 20)));
            queue_effect_runs(300);
            if (ph == 0) begin
                while (pending.size() > 150) @(negedge i_clk);
                send_hold = 1'b1;
                @(negedge i_clk);
                while (i_in_valid || drive_expected.size() != 0) @(negedge i_clk);
                repeat (20) @(negedge i_clk);
                send_hold = 1'b0;
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && drive_expected.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/les_pkg.sv
rtl/les_regs.sv
rtl/les_breathe_rom.sv
rtl/les_engine.sv
rtl/led_identify_effect_sequencer.sv
bench/led_identify_effect_sequencer_test.sv
